>>> rtl/core/uabq_pkg.sv
package uabq_pkg;

	localparam int DEF_SEND_DEPTH = 64;
	localparam int DEF_RECV_DEPTH = 64;

	typedef enum logic [1:0] {
		ACT_SEND  = 2'd0,
		ACT_TAKE  = 2'd1,
		ACT_TXE   = 2'd2,
		ACT_RECV  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_NODATA = 2'd2
	} status_t;

	typedef struct packed {
		logic empty;
		logic full;
	} ring_flags_t;

endpackage

>>> rtl/core/uart_buffered_tx_rx_queues.sv
// one item per cycle while out_stall is low; the result is registered and shown in the cycle after the transfer
// and ring reads come from the registered port of each ring memory
// in_stall is high while a result waits under out_stall, so one item is in flight at a time
// reset: rings empty, transmitter marked idle, empty interrupt off, no result pending
// ring memories are not cleared; no sweep after reset
module uart_buffered_tx_rx_queues #(
	parameter int SEND_DEPTH = uabq_pkg::DEF_SEND_DEPTH,
	parameter int RECV_DEPTH = uabq_pkg::DEF_RECV_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] action,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] read_byte,
	output logic       read_valid,
	output logic [7:0] line_byte,
	output logic       line_valid,
	output logic       tx_irq_enable,
	output logic       rx_pending
);
	import uabq_pkg::*;

	ring_flags_t tx_flags, rx_flags;
	logic [7:0]  tx_rd, rx_rd;
	logic        accept;
	action_t     act;
	logic        tx_push, tx_pop, rx_push, rx_pop;
	status_t     status_d, status_q;
	logic        valid_q, rvalid_q, lvalid_q;
	logic        restart_q, irq_q, restart_d, irq_d;

	assign in_stall = valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign act      = action_t'(action);

	always_comb begin
		tx_push   = 1'b0;
		tx_pop    = 1'b0;
		rx_push   = 1'b0;
		rx_pop    = 1'b0;
		status_d  = ST_OK;
		restart_d = restart_q;
		irq_d     = irq_q;
		unique case (act)
			ACT_SEND: begin
				if (tx_flags.full) begin
					status_d = ST_FULL;
				end else begin
					tx_push = 1'b1;
					if (restart_q) begin
						restart_d = 1'b0;
						irq_d     = 1'b1;
					end
				end
			end
			ACT_TAKE: begin
				if (rx_flags.empty) begin
					status_d = ST_NODATA;
				end else begin
					rx_pop = 1'b1;
				end
			end
			ACT_TXE: begin
				// handled whatever the interrupt enable
				if (!tx_flags.empty) begin
					tx_pop    = 1'b1;
					restart_d = 1'b0;
				end else begin
					restart_d = 1'b1;
					irq_d     = 1'b0;
				end
			end
			ACT_RECV: begin
				if (rx_flags.full) begin
					status_d = ST_FULL;
				end else begin
					rx_push = 1'b1;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	uabq_ring #(
		.DEPTH (SEND_DEPTH)
	) u_tx_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && tx_push),
		.push_data (data_byte),
		.pop       (accept && tx_pop),
		.flags     (tx_flags),
		.rd_data   (tx_rd)
	);

	uabq_ring #(
		.DEPTH (RECV_DEPTH)
	) u_rx_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && rx_push),
		.push_data (data_byte),
		.pop       (accept && rx_pop),
		.flags     (rx_flags),
		.rd_data   (rx_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			restart_q <= 1'b1;
			irq_q     <= 1'b0;
			status_q  <= ST_OK;
			rvalid_q  <= 1'b0;
			lvalid_q  <= 1'b0;
		end else begin
			if (accept) begin
				valid_q   <= 1'b1;
				restart_q <= restart_d;
				irq_q     <= irq_d;
				status_q  <= status_d;
				rvalid_q  <= accept && rx_pop;
				lvalid_q  <= accept && tx_pop;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// flags and pointers only move on a transfer, so they hold under a stalled result
	assign out_valid     = valid_q;
	assign status        = status_q;
	assign read_valid    = rvalid_q;
	assign read_byte     = rvalid_q ? rx_rd : 8'h00;
	assign line_valid    = lvalid_q;
	assign line_byte     = lvalid_q ? tx_rd : 8'h00;
	assign tx_irq_enable = irq_q;
	assign rx_pending    = !rx_flags.empty;

endmodule

>>> rtl/core/uabq_ring.sv
module uabq_ring #(
	parameter int DEPTH = uabq_pkg::DEF_SEND_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [7:0]             push_data,
	input  logic                   pop,
	output uabq_pkg::ring_flags_t  flags,
	output logic [7:0]             rd_data
);
	import uabq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	// counter = wrap * DEPTH + index, so it runs modulo twice the depth
	logic [AW-1:0] head_idx_q, tail_idx_q;
	logic          head_wrap_q, tail_wrap_q;
	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_idx_q  <= '0;
			head_wrap_q <= 1'b0;
			tail_idx_q  <= '0;
			tail_wrap_q <= 1'b0;
		end else begin
			if (push) begin
				if (head_idx_q == LAST) begin
					head_idx_q  <= '0;
					head_wrap_q <= ~head_wrap_q;
				end else begin
					head_idx_q <= head_idx_q + AW'(1);
				end
			end
			if (pop) begin
				if (tail_idx_q == LAST) begin
					tail_idx_q  <= '0;
					tail_wrap_q <= ~tail_wrap_q;
				end else begin
					tail_idx_q <= tail_idx_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[head_idx_q] <= push_data;
		end
	end

	// read data holds until the next pop
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_data_q <= mem[tail_idx_q];
		end
	end

	assign flags.empty = (head_idx_q == tail_idx_q) && (head_wrap_q == tail_wrap_q);
	assign flags.full  = (head_idx_q == tail_idx_q) && (head_wrap_q != tail_wrap_q);
	assign rd_data     = rd_data_q;

endmodule
